// File: hdl/tdfa_pkg.sv
// tdfa_pkg: shared types and codes for the table driven dfa acceptor
// operation codes, reject causes, register indices, parameter defaults and the match result struct
// no dependencies
package tdfa_pkg;

  localparam int MAX_STATES_DEF  = 16;
  localparam int MAX_SYMBOLS_DEF = 16;

  // widest symbol slot index over the supported range of slot counts
  localparam int SYM_IDX_MAX_W = 6;

  localparam logic [1:0] OP_SYMBOL = 2'd0;
  localparam logic [1:0] OP_TRANS  = 2'd1;
  localparam logic [1:0] OP_CHAR   = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_UNKNOWN = 2'd1;
  localparam logic [1:0] CAUSE_MISSING = 2'd2;

  localparam logic [1:0] REG_START       = 2'd0;
  localparam logic [1:0] REG_SYM_COUNT   = 2'd1;
  localparam logic [1:0] REG_ACCEPT_MASK = 2'd2;

  typedef struct packed {
    logic                     hit;
    logic [SYM_IDX_MAX_W-1:0] slot;
  } match_t;

endpackage

// File: hdl/tdfa_if.sv
// tdfa_if: valid/ready channel interfaces for the dfa acceptor
// input item, result item and register write channels; no dependencies
interface tdfa_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [3:0]        slot;
  logic [3:0]        from_state;
  logic [7:0]        char_value;
  logic signed [4:0] to_state;

  modport source (output valid, operation, slot, from_state, char_value, to_state,
                  input ready);
  modport sink   (input valid, operation, slot, from_state, char_value, to_state,
                  output ready);
endinterface

interface tdfa_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [3:0] final_state;
  logic [1:0] reject_cause;

  modport source (output valid, accepted, final_state, reject_cause, input ready);
  modport sink   (input valid, accepted, final_state, reject_cause, output ready);
endinterface

interface tdfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/tdfa_match.sv
// tdfa_match: symbol table registers and lowest-slot character matcher
// depends on tdfa_pkg
module tdfa_match #(
  parameter int MAX_SYMBOLS = tdfa_pkg::MAX_SYMBOLS_DEF
) (
  input  logic             clk,
  input  logic             sym_we,
  input  logic [3:0]       sym_slot,
  input  logic [7:0]       sym_char,
  input  logic [7:0]       ch,
  input  logic [4:0]       sym_count,
  output tdfa_pkg::match_t match
);
  import tdfa_pkg::*;

  localparam int SYM_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  logic [7:0] sym_r [MAX_SYMBOLS];

  always_ff @(posedge clk) begin
    if (sym_we && (32'(sym_slot) < MAX_SYMBOLS)) begin
      sym_r[SYM_W'(sym_slot)] <= sym_char;
    end
  end

  // walk downwards so the lowest matching slot is the one left standing
  always_comb begin
    match = '0;
    for (int j = MAX_SYMBOLS - 1; j >= 0; j--) begin
      if ((j < 32'(sym_count)) && (sym_r[j] == ch)) begin
        match.hit  = 1'b1;
        match.slot = SYM_IDX_MAX_W'(j);
      end
    end
  end

endmodule

// File: hdl/table_driven_dfa_acceptor_core.sv
// table_driven_dfa_acceptor_core: top level of the table driven dfa string acceptor
// transition table memory, string state and result register
// depends on tdfa_pkg, tdfa_if and tdfa_match
//
// usage
//   cfg_ch writes the start state (index 0), the symbol count (1) and the accept
//   mask (2). it is always ready; the user must write it only while the block is
//   idle, which the block itself does not enforce. in_ch carries items: symbol slot
//   writes, transition writes, characters and end of string. only an end of
//   string item yields a result on out_ch: accepted, final_state and reject_cause.
//   symbol, transition and end items need no wait state. for a character, the
//   lowest matching symbol slot addresses the transition memory, whose registered
//   read sits in the state feedback loop; in_ch is held not ready while that read
//   completes. the result is registered and shows in the cycle after the end item
//   is taken. after reset the transition memory is swept to no transition, one
//   entry a cycle, MAX_STATES * MAX_SYMBOLS entries in all; in_ch is held not ready
//   meanwhile. while a result waits on a stalled out_ch, in_ch stays not ready
//   unless the result is taken in that same cycle.
module table_driven_dfa_acceptor_core #(
  parameter int MAX_STATES  = tdfa_pkg::MAX_STATES_DEF,
  parameter int MAX_SYMBOLS = tdfa_pkg::MAX_SYMBOLS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tdfa_cfg_if.sink   cfg_ch,
  tdfa_in_if.sink    in_ch,
  tdfa_out_if.source out_ch
);
  import tdfa_pkg::*;

  localparam int SYM_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int ST_W   = $clog2(MAX_STATES);
  localparam int CS_W   = (ST_W > 4) ? ST_W : 4;
  localparam int DEPTH  = MAX_STATES * MAX_SYMBOLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration registers
  logic [3:0]  start_r;
  logic [4:0]  num_sym_r;
  logic [15:0] mask_r;

  // string state
  logic [CS_W-1:0] cur_r, cur_nxt;
  logic [1:0]      dead_r, dead_nxt;
  logic            in_string_r, in_string_nxt;
  logic            wait_r, wait_nxt;

  // clearing sweep
  logic              clear_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       acc_r, acc_nxt;
  logic [3:0] fin_r, fin_nxt;
  logic [1:0] cause_r, cause_nxt;

  // transition memory, entry is {valid, target state}
  logic [ST_W:0]     tt_mem [DEPTH];
  logic [ST_W:0]     rd_q_r;
  logic              mem_we, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [ST_W:0]     wr_data;

  logic            in_ready, in_acc;
  logic [CS_W-1:0] eff_state;
  logic            trans_ok, trans_in_range;
  logic [4:0]      nraw;
  match_t          match;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      num_sym_r <= '0;
      mask_r    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_START:       start_r   <= cfg_ch.data[3:0];
        REG_SYM_COUNT:   num_sym_r <= cfg_ch.data[4:0];
        REG_ACCEPT_MASK: mask_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ready    = !clear_r && !wait_r && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  tdfa_match #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_match (
    .clk        (clk),
    .sym_we     (in_acc && (in_ch.operation == OP_SYMBOL)),
    .sym_slot   (in_ch.slot),
    .sym_char   (in_ch.char_value),
    .ch         (in_ch.char_value),
    .sym_count  (num_sym_r),
    .match      (match)
  );

  assign eff_state = in_string_r ? cur_r : CS_W'(start_r);
  assign nraw      = $unsigned(in_ch.to_state);
  assign trans_in_range = (32'(in_ch.slot) < MAX_SYMBOLS) && (32'(in_ch.from_state) < MAX_STATES);
  // negative targets and targets beyond the state count store as no transition
  assign trans_ok  = !nraw[4] && (32'(nraw) < MAX_STATES);

  // memory write side: sweep first, then transition writes
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = '0;
    if (clear_r) begin
      mem_we = 1'b1;
    end else if (in_acc && (in_ch.operation == OP_TRANS) && trans_in_range) begin
      mem_we  = 1'b1;
      wr_addr = ADDR_W'(ADDR_W'(in_ch.from_state) * ADDR_W'(MAX_SYMBOLS))
                + ADDR_W'(in_ch.slot);
      wr_data = trans_ok ? {1'b1, ST_W'(nraw)} : '0;
    end
  end

  assign rd_addr = ADDR_W'(ADDR_W'(eff_state) * ADDR_W'(MAX_SYMBOLS))
                   + ADDR_W'(match.slot[SYM_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tt_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= tt_mem[rd_addr];
    end
  end

  always_comb begin
    cur_nxt       = cur_r;
    dead_nxt      = dead_r;
    in_string_nxt = in_string_r;
    wait_nxt      = 1'b0;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    acc_nxt       = acc_r;
    fin_nxt       = fin_r;
    cause_nxt     = cause_r;
    if (wait_r) begin
      if (!rd_q_r[ST_W]) begin
        dead_nxt = CAUSE_MISSING;
      end else begin
        cur_nxt = CS_W'(rd_q_r[ST_W-1:0]);
      end
    end else if (in_acc) begin
      case (in_ch.operation)
        OP_CHAR: begin
          in_string_nxt = 1'b1;
          cur_nxt       = eff_state;
          if (dead_r == CAUSE_NONE) begin
            if (!match.hit) begin
              dead_nxt = CAUSE_UNKNOWN;
            end else if (32'(eff_state) >= MAX_STATES) begin
              dead_nxt = CAUSE_MISSING;
            end else begin
              rd_en    = 1'b1;
              wait_nxt = 1'b1;
            end
          end
        end
        OP_END: begin
          out_valid_nxt = 1'b1;
          cause_nxt     = dead_r;
          acc_nxt       = (dead_r == CAUSE_NONE) && (32'(eff_state) < 16)
                          && mask_r[eff_state[3:0]];
          fin_nxt       = (dead_r == CAUSE_NONE) ? eff_state[3:0] : 4'd0;
          in_string_nxt = 1'b0;
          dead_nxt      = CAUSE_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      dead_r      <= CAUSE_NONE;
      in_string_r <= 1'b0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      clear_r     <= 1'b1;
      clr_cnt_r   <= '0;
    end else begin
      cur_r       <= cur_nxt;
      dead_r      <= dead_nxt;
      in_string_r <= in_string_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
      if (clear_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          clear_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    fin_r   <= fin_nxt;
    cause_r <= cause_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = acc_r;
  assign out_ch.final_state  = fin_r;
  assign out_ch.reject_cause = cause_r;

  a_no_item_in_sweep : assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !in_ch.ready)
    else $error("item taken during transition memory sweep");

  a_wait_one_cycle : assert property (@(posedge clk) disable iff (!rst_n)
    wait_r |=> !wait_r)
    else $error("memory wait lasted more than one cycle");

  a_end_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.operation == OP_END)) |=> out_valid_r)
    else $error("end of string item gave no result");

  a_accept_not_dead : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && acc_r) |-> (cause_r == CAUSE_NONE))
    else $error("accepted string carries a reject cause");

  a_wait_follows_read : assert property (@(posedge clk) disable iff (!rst_n)
    wait_r |-> $past(rd_en))
    else $error("memory wait without a read");

endmodule
